/* rtl/led_matrix_chain_refresher_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef LED_MATRIX_CHAIN_REFRESHER_DEFINES_SVH
`define LED_MATRIX_CHAIN_REFRESHER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LMCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmcr: check failed");

// Next-cycle implication, disabled in reset.
`define LMCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmcr: check failed");

`endif

/* rtl/lmcr_pkg.sv */
package lmcr_pkg;

  localparam int MATRIX_COUNT = 8;   // matrices in the chain, 1..8
  localparam int CHAIN_SLOTS  = 8;   // bytes in one chain result
  localparam int GRID         = 8;   // rows and columns per matrix

  localparam int CMD_W      = 2;
  localparam int MAT_W      = 3;
  localparam int COL_W      = 3;
  localparam int PIX_W      = 4;
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int CHAIN_W    = CHAIN_SLOTS * BYTE_W;
  localparam int DIGIT_W    = 4;
  localparam int TICK_W     = 13;
  localparam int REMAP_W    = 48;
  localparam int FIELD_W    = 3;
  localparam int ROW_MAP_LSB = 24;
  localparam int REG_COUNT  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int REG_IDX_W  = 3;

  localparam logic [REMAP_W-1:0] REMAP_RESET = 48'hFAC688FAC688;
  localparam logic [WORD_W-1:0]  LINE_ON_WORD = 32'h11111111;
  localparam logic [WORD_W-1:0]  PIX_ON_WORD  = 32'h00000001;
  localparam logic [BYTE_W-1:0]  ROW_TOP_BIT  = 8'h80;
  localparam logic [PIX_W-1:0]   PIX_OFF      = 4'h0;
  localparam logic [PIX_W-1:0]   PIX_ON       = 4'h1;
  localparam logic [PIX_W-1:0]   PIX_CLEAR    = 4'hF;
  localparam logic [PIX_W-1:0]   BLINK_BASE   = 4'h2;
  localparam logic [COL_W-1:0]   CNT_LAST     = COL_W'(GRID - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_LAST   = DIGIT_W'(GRID);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_COL = 2'd0,
    CMD_HLINE     = 2'd1,
    CMD_VLINE     = 2'd2,
    CMD_REFRESH   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              clear;
  } lane_ctrl_t;

  function automatic logic pixel_lit(input logic [PIX_W-1:0] colour,
                                     input logic [TICK_W-1:0] tick);
    logic [PIX_W-1:0] sh;
    logic lit;
    sh = colour - BLINK_BASE;
    if (colour == PIX_OFF || colour == PIX_CLEAR) begin
      lit = 1'b0;
    end else if (colour == PIX_ON) begin
      lit = 1'b1;
    end else begin
      lit = tick[sh];
    end
    return lit;
  endfunction

  // Lit-row byte of one column word after the row remap; shared targets OR.
  function automatic logic [BYTE_W-1:0] column_pattern(input logic [WORD_W-1:0] word,
                                                       input logic [REMAP_W-1:0] remap,
                                                       input logic [TICK_W-1:0] tick);
    logic [BYTE_W-1:0] pat;
    logic [FIELD_W-1:0] rt;
    pat = '0;
    for (int r = 0; r < GRID; r++) begin
      rt = remap[ROW_MAP_LSB + FIELD_W*r +: FIELD_W];
      if (pixel_lit(word[PIX_W*r +: PIX_W], tick)) begin
        pat = pat | (ROW_TOP_BIT >> rt);
      end
    end
    return pat;
  endfunction

endpackage

/* rtl/lmcr_in_if.sv */
interface lmcr_in_if;
  import lmcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [MAT_W-1:0]  matrix_index;
  logic [COL_W-1:0]  column_index;
  logic [COL_W-1:0]  line_index;
  logic [WORD_W-1:0] column_pixels;

  modport source (output valid, cmd, matrix_index, column_index, line_index,
                  column_pixels, input ready);
  modport sink (input valid, cmd, matrix_index, column_index, line_index,
                column_pixels, output ready);
endinterface

/* rtl/lmcr_out_if.sv */
interface lmcr_out_if;
  import lmcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_register;
  logic [CHAIN_W-1:0] chain_bytes;
  logic               last_column;

  modport source (output valid, digit_register, chain_bytes, last_column,
                  input ready);
  modport sink (input valid, digit_register, chain_bytes, last_column,
                output ready);
endinterface

/* rtl/lmcr_ram.sv */
module lmcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lmcr_lane.sv */
module lmcr_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  lmcr_pkg::lane_ctrl_t            ctrl,
  input  logic [lmcr_pkg::REMAP_W-1:0]    remap,
  input  logic [lmcr_pkg::TICK_W-1:0]     tick,
  input  logic [lmcr_pkg::COL_W-1:0]      out_col,
  output logic [lmcr_pkg::BYTE_W-1:0]     byte_out
);
  import lmcr_pkg::*;

  logic [GRID-1:0]    vld;        // column written since reset
  logic               comp_valid;
  logic [COL_W-1:0]   comp_col;
  logic               comp_hit;
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  word;
  logic [FIELD_W-1:0] target;
  logic [BYTE_W-1:0]  pattern;
  logic [BYTE_W-1:0]  col_bytes [GRID];

  lmcr_ram #(.WIDTH(WORD_W), .DEPTH(GRID)) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (ctrl.wr_addr),
    .wdata (ctrl.wr_data),
    .re    (ctrl.rd_en),
    .raddr (ctrl.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      comp_valid <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        vld[ctrl.wr_addr] <= 1'b1;
      end
      comp_valid <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      comp_col <= ctrl.rd_addr;
      comp_hit <= vld[ctrl.rd_addr];
    end
  end

  always_comb begin
    word    = comp_hit ? rdata : '0;
    target  = remap[FIELD_W*int'(comp_col) +: FIELD_W];
    pattern = column_pattern(word, remap, tick);
  end

  // Columns arrive in ascending order, so the highest source column wins.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int i = 0; i < GRID; i++) begin
        col_bytes[i] <= '0;
      end
    end else if (comp_valid) begin
      col_bytes[target] <= pattern;
    end
  end

  assign byte_out = col_bytes[out_col];

endmodule

/* rtl/lmcr_merge.sv */
module lmcr_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [lmcr_pkg::COL_W-1:0]    col,
  input  logic [lmcr_pkg::BYTE_W-1:0]   lane_bytes [lmcr_pkg::MATRIX_COUNT],
  output logic                          can_load,
  lmcr_out_if.source                    out_ch
);
  import lmcr_pkg::*;

  logic [CHAIN_W-1:0] chain;

  for (genvar m = 0; m < CHAIN_SLOTS; m++) begin : g_slot
    if (m < MATRIX_COUNT) begin : g_used
      assign chain[BYTE_W*m +: BYTE_W] = lane_bytes[m];
    end else begin : g_empty
      assign chain[BYTE_W*m +: BYTE_W] = '0;
    end
  end

  assign can_load = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.digit_register <= DIGIT_W'(col) + DIGIT_W'(1);
      out_ch.chain_bytes    <= chain;
      out_ch.last_column    <= (col == CNT_LAST);
    end
  end

endmodule

/* rtl/led_matrix_chain_refresher.sv */
// Column write: written on accept, ready stays high. Line command: ready drops while S_FILL
// writes one word per cycle. Refresh: lanes read one column per cycle from their column RAMs
// in S_SCAN, S_DRAIN lets the last one settle, then one item per cycle leaves the output
// register while the sink is ready. The output register frees the input side once the
// eighth item is loaded. Sync reset clears the framebuffer valid bits (columns read as zero),
// blink tick, remaps to identity, handshakes.
module led_matrix_chain_refresher (
  input  logic                            clk,
  input  logic                            rst,
  lmcr_in_if.sink                         in_ch,
  lmcr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lmcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmcr_pkg::REMAP_W-1:0]    cfg_data
);
  import lmcr_pkg::*;
  `include "led_matrix_chain_refresher_defines.svh"

  // Control
  state_t             state, state_next;
  logic [COL_W-1:0]   cnt, cnt_next;
  logic [TICK_W-1:0]  tick;
  logic               in_accept;

  // Latched line command
  logic [MAT_W-1:0]   fill_matrix;
  logic [COL_W-1:0]   fill_line;
  logic               fill_vert;

  // Per-matrix remap registers
  logic [REMAP_W-1:0] remap [REG_COUNT];

  // Shared lane controls before per-lane write select
  logic               wr_en_any;
  logic [MAT_W-1:0]   wr_mat;
  logic [COL_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               scan_clear;
  logic               emit_load;
  logic               can_load;

  lane_ctrl_t         lane_ctrl  [MATRIX_COUNT];
  logic [BYTE_W-1:0]  lane_bytes [MATRIX_COUNT];

  assign in_ch.ready = (state == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Config: writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        remap[i] <= REMAP_RESET;
      end
    end else if (cfg_we && int'(cfg_index) < REG_COUNT) begin
      remap[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      tick  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      // Tick moves once the last column of a refresh has been evaluated.
      if (state == S_DRAIN) begin
        tick <= tick + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fill_matrix <= in_ch.matrix_index;
      fill_line   <= in_ch.line_index;
      fill_vert   <= (cmd_t'(in_ch.cmd) == CMD_VLINE);
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wr_en_any  = 1'b0;
    wr_mat     = in_ch.matrix_index;
    wr_addr    = in_ch.column_index;
    wr_data    = in_ch.column_pixels;
    scan_clear = 1'b0;
    emit_load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (cmd_t'(in_ch.cmd))
            CMD_REFRESH: begin
              scan_clear = 1'b1;
              cnt_next   = '0;
              state_next = S_SCAN;
            end
            CMD_WRITE_COL: begin
              // Matrices past the chain end ignore writes.
              wr_en_any = (int'(in_ch.matrix_index) < MATRIX_COUNT);
            end
            default: begin
              if (int'(in_ch.matrix_index) < MATRIX_COUNT) begin
                cnt_next   = '0;
                state_next = S_FILL;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        wr_en_any = 1'b1;
        wr_mat    = fill_matrix;
        wr_addr   = cnt;
        if (fill_vert) begin
          wr_data = (cnt == fill_line) ? LINE_ON_WORD : '0;
        end else begin
          wr_data = PIX_ON_WORD << (PIX_W * int'(fill_line));
        end
        cnt_next = cnt + COL_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cnt_next = cnt + COL_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Last column lands in the lane byte store this cycle.
        cnt_next   = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          emit_load = 1'b1;
          cnt_next  = cnt + COL_W'(1);
          if (cnt == CNT_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // One lane per matrix: column RAM, pattern logic and byte store.
  for (genvar m = 0; m < MATRIX_COUNT; m++) begin : g_lane
    always_comb begin
      lane_ctrl[m].wr_en   = wr_en_any && (wr_mat == MAT_W'(m));
      lane_ctrl[m].wr_addr = wr_addr;
      lane_ctrl[m].wr_data = wr_data;
      lane_ctrl[m].rd_en   = (state == S_SCAN);
      lane_ctrl[m].rd_addr = cnt;
      lane_ctrl[m].clear   = scan_clear;
    end

    lmcr_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl[m]),
      .remap    (remap[m]),
      .tick     (tick),
      .out_col  (cnt),
      .byte_out (lane_bytes[m])
    );
  end

  // Gathers lane bytes into the chain word and holds the output register.
  lmcr_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (emit_load),
    .col        (cnt),
    .lane_bytes (lane_bytes),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

  `LMCR_ASSERT_IMP(a_last_is_digit8, out_ch.valid && out_ch.last_column, out_ch.digit_register == DIGIT_LAST)
  `LMCR_ASSERT_NXT(a_tick_only_on_drain, state != S_DRAIN, $stable(tick))
  `LMCR_ASSERT_NXT(a_last_emit_flags, emit_load && cnt == CNT_LAST, out_ch.valid && out_ch.last_column)
  `LMCR_ASSERT_IMP(a_no_write_in_scan, state == S_SCAN || state == S_DRAIN, !wr_en_any)

endmodule

/* verif/chain_refresh_checker.sv */
`timescale 1ns / 100ps

module chain_refresh_checker (
  input  logic                           clk,
  input  logic                           rst,
  lmcr_in_if                             in_ch,
  lmcr_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [lmcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmcr_pkg::REMAP_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import lmcr_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CHAIN_W-1:0] chain;
    logic               last;
  } column_result_t;

  logic [WORD_W-1:0]  frame [MATRIX_COUNT*GRID];
  logic [REMAP_W-1:0] remaps [REG_COUNT];
  logic [TICK_W-1:0]  tick;
  column_result_t     expected_columns [$];
  int                 bad_items;

  // Row byte of one column word: lit rows set bit (7 - target).
  function automatic logic [BYTE_W-1:0] lit_rows(input logic [WORD_W-1:0]  word,
                                                 input logic [REMAP_W-1:0] map,
                                                 input logic [TICK_W-1:0]  t);
    logic [BYTE_W-1:0]  rows;
    logic [PIX_W-1:0]   colour;
    logic [FIELD_W-1:0] target;
    logic               on;
    rows = '0;
    for (int r = 0; r < GRID; r++) begin
      colour = word[PIX_W*r +: PIX_W];
      target = map[ROW_MAP_LSB + FIELD_W*r +: FIELD_W];
      case (colour)
        PIX_OFF, PIX_CLEAR: on = 1'b0;
        PIX_ON:             on = 1'b1;
        default:            on = t[colour - BLINK_BASE];
      endcase
      if (on) begin
        rows[BYTE_W-1 - target] = 1'b1;
      end
    end
    return rows;
  endfunction

  // Eight column results of one refresh; later source columns overwrite.
  task automatic predict_refresh();
    logic [GRID-1:0][CHAIN_W-1:0] chains;
    logic [FIELD_W-1:0]           dest;
    column_result_t               res;
    chains = '0;
    for (int m = 0; m < MATRIX_COUNT; m++) begin
      for (int c = 0; c < GRID; c++) begin
        dest = remaps[m][FIELD_W*c +: FIELD_W];
        chains[dest][BYTE_W*m +: BYTE_W] = lit_rows(frame[m*GRID + c], remaps[m], tick);
      end
    end
    for (int o = 0; o < GRID; o++) begin
      res.digit = DIGIT_W'(o + 1);
      res.chain = chains[o];
      res.last  = (o == GRID - 1);
      expected_columns.push_back(res);
    end
    tick = tick + 1'b1;
  endtask

  always @(posedge clk) begin
    column_result_t    want;
    logic [MAT_W-1:0]  m;
    if (rst) begin
      for (int i = 0; i < MATRIX_COUNT*GRID; i++) frame[i] = '0;
      for (int i = 0; i < REG_COUNT; i++) remaps[i] = REMAP_RESET;
      tick = '0;
      expected_columns.delete();
      bad_items = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_columns.size() == 0) begin
          bad_items++;
          if (bad_items <= MAX_REPORTS) begin
            $display("chk: unexpected item digit %0d chain %h last %0d",
                     out_ch.digit_register, out_ch.chain_bytes, out_ch.last_column);
          end
        end else begin
          want = expected_columns.pop_front();
          if (out_ch.digit_register !== want.digit || out_ch.chain_bytes !== want.chain ||
              out_ch.last_column !== want.last) begin
            bad_items++;
            if (bad_items <= MAX_REPORTS) begin
              $display("chk: exp digit %0d chain %h last %0d, got digit %0d chain %h last %0d",
                       want.digit, want.chain, want.last,
                       out_ch.digit_register, out_ch.chain_bytes, out_ch.last_column);
            end
          end
        end
      end
      if (cfg_we && cfg_index < REG_COUNT) begin
        remaps[cfg_index[REG_IDX_W-1:0]] = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        m = in_ch.matrix_index;
        if (in_ch.cmd == CMD_REFRESH) begin
          predict_refresh();
        end else if (m < MATRIX_COUNT) begin
          case (in_ch.cmd)
            CMD_WRITE_COL: frame[m*GRID + in_ch.column_index] = in_ch.column_pixels;
            CMD_HLINE: begin
              for (int c = 0; c < GRID; c++) begin
                frame[m*GRID + c] = PIX_ON_WORD << (PIX_W*in_ch.line_index);
              end
            end
            default: begin
              for (int c = 0; c < GRID; c++) begin
                frame[m*GRID + c] = (c == in_ch.line_index) ? LINE_ON_WORD : '0;
              end
            end
          endcase
        end
      end
    end
    mismatches <= bad_items;
    pending    <= expected_columns.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lmcr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;   // long enough for a line command or refresh to finish
  localparam int LONG_HOLD     = 300;  // receiver hold-off, long enough to back up the input
  localparam int PHASE_ITEMS   = 39;

  // Remap programming styles
  typedef enum int {
    MAP_IDENTITY,
    MAP_ZEROS,
    MAP_ONES,
    MAP_RANDOM,
    MAP_SHUFFLE
  } map_style_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REMAP_W-1:0]   cfg_data;
  int                   mismatches;
  int                   pending;
  int                   cycles;

  // Idle knobs, read by the driver and the ready process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long hold-off requests: stimulus bumps hold_reqs, ready process serves them
  int hold_reqs   = 0;
  int hold_served;
  int hold_left;

  lmcr_in_if  in_ch ();
  lmcr_out_if out_ch ();

  led_matrix_chain_refresher DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chain_refresh_checker column_check (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Output side: random stalls, plus the occasional long hold-off counted here
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_served != hold_reqs) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item; idle cycles before it carry junk with valid low.
  // Returns at the edge that accepts it, valid still high.
  task automatic offer_command(input cmd_t              cmd,
                               input logic [MAT_W-1:0]  mat,
                               input logic [COL_W-1:0]  col,
                               input logic [COL_W-1:0]  line,
                               input logic [WORD_W-1:0] pixels);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= CMD_W'($urandom);
      in_ch.matrix_index  <= MAT_W'($urandom);
      in_ch.column_index  <= COL_W'($urandom);
      in_ch.line_index    <= COL_W'($urandom);
      in_ch.column_pixels <= $urandom;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.matrix_index  <= mat;
    in_ch.column_index  <= col;
    in_ch.line_index    <= line;
    in_ch.column_pixels <= pixels;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random item: refresh-heavy mix; half the pixel words are built from the
  // interesting colours (off, on, transparent, blink) so rows actually light.
  task automatic offer_random();
    int                pick;
    cmd_t              cmd;
    logic [WORD_W-1:0] pixels;
    pick = $urandom_range(99);
    if (pick < 35) begin
      cmd = CMD_REFRESH;
    end else if (pick < 70) begin
      cmd = CMD_WRITE_COL;
    end else if (pick < 85) begin
      cmd = CMD_HLINE;
    end else begin
      cmd = CMD_VLINE;
    end
    if ($urandom_range(1) == 0) begin
      pixels = $urandom;
    end else begin
      for (int r = 0; r < GRID; r++) begin
        case ($urandom_range(3))
          0:       pixels[PIX_W*r +: PIX_W] = PIX_OFF;
          1:       pixels[PIX_W*r +: PIX_W] = PIX_ON;
          2:       pixels[PIX_W*r +: PIX_W] = PIX_CLEAR;
          default: pixels[PIX_W*r +: PIX_W] = PIX_W'($urandom_range(14, 2));
        endcase
      end
    end
    offer_command(cmd, MAT_W'($urandom), COL_W'($urandom), COL_W'($urandom), pixels);
  endtask

  // Drop valid, wait for every expected item, then let a line command finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight remaps in one style, then one write past the last index
  // which the block must drop.
  task automatic program_remaps(input map_style_t style);
    logic [REMAP_W-1:0] value;
    int                 perm [GRID];
    int                 j;
    int                 tmp;
    for (int i = 0; i <= REG_COUNT; i++) begin
      case (style)
        MAP_IDENTITY: value = REMAP_RESET;
        MAP_ZEROS:    value = '0;
        MAP_ONES:     value = '1;
        MAP_RANDOM:   value = REMAP_W'({$urandom, $urandom});
        default: begin
          // column half then row half, each a random permutation
          for (int half = 0; half < 2; half++) begin
            for (int k = 0; k < GRID; k++) perm[k] = k;
            for (int k = GRID - 1; k > 0; k--) begin
              j       = $urandom_range(k);
              tmp     = perm[k];
              perm[k] = perm[j];
              perm[j] = tmp;
            end
            for (int k = 0; k < GRID; k++) begin
              value[ROW_MAP_LSB*half + FIELD_W*k +: FIELD_W] = FIELD_W'(perm[k]);
            end
          end
        end
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= (i < REG_COUNT) ? CFG_IDX_W'(i) : CFG_IDX_W'($urandom_range(15, REG_COUNT));
      cfg_data  <= value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_WRITE_COL;
    in_ch.matrix_index  = '0;
    in_ch.column_index  = '0;
    in_ch.line_index    = '0;
    in_ch.column_pixels = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, identity remaps from reset
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);  // cleared store
    offer_command(CMD_WRITE_COL, 3'd0, 3'd0, 3'd7, 32'hFFFFFFFF);  // all transparent
    offer_command(CMD_WRITE_COL, 3'd0, 3'd7, 3'd0, 32'h11111111);  // all on
    offer_command(CMD_WRITE_COL, 3'd7, 3'd0, 3'd0, 32'h76543210);  // every colour 0..7
    offer_command(CMD_WRITE_COL, 3'd7, 3'd7, 3'd7, 32'hFEDCBA98);  // every colour 8..15
    offer_command(CMD_WRITE_COL, 3'd3, 3'd5, 3'd0, 32'h10000001);  // top and bottom rows
    // walk the blink tick
    offer_command(CMD_REFRESH,   3'd7, 3'd7, 3'd7, 32'hFFFFFFFF);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    // line commands at both ends of the line range
    offer_command(CMD_HLINE,     3'd1, 3'd0, 3'd0, 32'h00000000);
    offer_command(CMD_HLINE,     3'd6, 3'd0, 3'd7, 32'h00000000);
    offer_command(CMD_VLINE,     3'd2, 3'd0, 3'd0, 32'h00000000);
    offer_command(CMD_VLINE,     3'd5, 3'd0, 3'd7, 32'h00000000);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    offer_command(CMD_WRITE_COL, 3'd4, 3'd2, 3'd0, 32'h5A5A5A5A);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    settle();

    // All-zero remaps: every column lands on output column 0 (highest wins),
    // all rows OR into the top bit, other output columns unmapped
    program_remaps(MAP_ZEROS);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    settle();

    // All-ones remaps: everything onto output column 7, rows onto bit 0
    program_remaps(MAP_ONES);
    offer_command(CMD_WRITE_COL, 3'd7, 3'd3, 3'd0, 32'h11111111);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    offer_command(CMD_REFRESH,   3'd0, 3'd0, 3'd0, 32'h00000000);
    settle();

    // Random phases, each with its own remaps and idle pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          program_remaps(MAP_SHUFFLE);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          program_remaps(MAP_RANDOM);
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          program_remaps(MAP_SHUFFLE);
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          program_remaps(MAP_IDENTITY);
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (phase == 0) begin
        // receiver holds off while refreshes keep coming: output fills,
        // input backs up until the hold ends
        hold_reqs++;
        repeat (6) offer_command(CMD_REFRESH, MAT_W'($urandom), COL_W'($urandom),
                                 COL_W'($urandom), $urandom);
      end
      repeat (PHASE_ITEMS) offer_random();
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lmcr_pkg.sv
rtl/lmcr_in_if.sv
rtl/lmcr_out_if.sv
rtl/lmcr_ram.sv
rtl/lmcr_lane.sv
rtl/lmcr_merge.sv
rtl/led_matrix_chain_refresher.sv
verif/chain_refresh_checker.sv
verif/testbench.sv
